FILE: src/bfba_pkg.sv
// Shared types and constants of the best-fit block allocator.
package bfba_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ADDR_BITS_DEF    = 32;

  // Fixed field widths of the stream beats.
  localparam int REQ_W     = 32;
  localparam int TGT_W     = 6;
  localparam int DADDR_W   = 32;
  localparam int BLKNUM_W  = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Reset value of the heap limit register.
  localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;

  // Request kinds carried on in_tuser.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status carried on out_tuser.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  // Table update broadcast to all cells.
  typedef enum logic [1:0] {
    CMT_NONE     = 2'd0,
    CMT_SET_FREE = 2'd1,
    CMT_CLR_FREE = 2'd2,
    CMT_APPEND   = 2'd3
  } commit_op_t;

  // Control part of the search token that walks along the cells.
  typedef struct packed {
    logic valid;
    logic found;
    logic was_free;
  } tok_ctl_t;

endpackage

FILE: src/bfba_cell.sv
// One table entry of the allocator with its stage of the search chain.
module bfba_cell #(
  parameter int MAX_BLOCKS = bfba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = bfba_pkg::ADDR_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request under way, held steady by the top level.
  input  logic                             req_kind,
  input  logic [bfba_pkg::REQ_W-1:0]       req_size,
  input  logic [$clog2(MAX_BLOCKS)-1:0]    req_target,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]  entry_count,
  // Token from the previous cell.
  input  bfba_pkg::tok_ctl_t               tok_ctl_i,
  input  logic [bfba_pkg::REQ_W-1:0]       tok_size_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0]    tok_idx_i,
  input  logic [ADDR_BITS-1:0]             tok_start_i,
  // Token to the next cell.
  output bfba_pkg::tok_ctl_t               tok_ctl_o,
  output logic [bfba_pkg::REQ_W-1:0]       tok_size_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]    tok_idx_o,
  output logic [ADDR_BITS-1:0]             tok_start_o,
  // Table update.
  input  bfba_pkg::commit_op_t             cmt_op,
  input  logic [$clog2(MAX_BLOCKS)-1:0]    cmt_idx,
  input  logic [ADDR_BITS-1:0]             cmt_start,
  input  logic [bfba_pkg::REQ_W-1:0]       cmt_size
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_NUM = CW'(IDX);

  // Entry contents; meaningful only once appended.
  logic [ADDR_BITS-1:0]      start_r;
  logic [bfba_pkg::REQ_W-1:0] size_r;
  logic                      free_r;

  logic [bfba_pkg::REQ_W-1:0] tok_size_r;
  logic [IW-1:0]             tok_idx_r;
  logic [ADDR_BITS-1:0]      tok_start_r;
  bfba_pkg::tok_ctl_t        tok_ctl_r;

  logic live;
  logic take;
  logic was_free_nxt;

  // Decide whether this entry replaces the candidate carried by the token.
  always_comb begin
    live = (MY_NUM < entry_count);
    if (req_kind == bfba_pkg::KIND_FREE) begin
      take = live && (req_target == MY_IDX);
    end else begin
      take = live && free_r && (size_r >= req_size) &&
             (!tok_ctl_i.found || (size_r < tok_size_i));
    end
    was_free_nxt = take ? free_r : tok_ctl_i.was_free;
  end

  // Token stage: valid, found and was_free are control, the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_ctl_r <= '0;
    end else begin
      tok_ctl_r.valid    <= tok_ctl_i.valid;
      tok_ctl_r.found    <= tok_ctl_i.found | take;
      tok_ctl_r.was_free <= was_free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_size_r  <= take ? size_r  : tok_size_i;
    tok_idx_r   <= take ? MY_IDX  : tok_idx_i;
    tok_start_r <= take ? start_r : tok_start_i;
  end

  // Entry update from the broadcast commit.
  always_ff @(posedge clk) begin
    if (cmt_idx == MY_IDX) begin
      unique case (cmt_op)
        bfba_pkg::CMT_SET_FREE: free_r <= 1'b1;
        bfba_pkg::CMT_CLR_FREE: free_r <= 1'b0;
        bfba_pkg::CMT_APPEND: begin
          start_r <= cmt_start;
          size_r  <= cmt_size;
          free_r  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign tok_ctl_o   = tok_ctl_r;
  assign tok_size_o  = tok_size_r;
  assign tok_idx_o   = tok_idx_r;
  assign tok_start_o = tok_start_r;

endmodule

FILE: src/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: control, heap top and the cell chain.
//
// Requests arrive as beats on the in_ stream: in_tuser selects allocate or free,
// in_tdata carries the requested size and the block to free. Every request gives
// exactly one result beat on the out_ stream: status on out_tuser, and the data
// address, block number and reuse flag on out_tdata.
// The user must write the heap limit over the cfg_ channel only while no request is
// in flight; the block itself does not enforce it. A request walks a token through a
// row of MAX_BLOCKS cells, one cell a cycle; each cell holds one table entry and
// keeps the best fitting free block seen so far, or the addressed block for a free.
// The token is launched from a register; when it leaves the last cell the result is
// registered, then moved to the output register once that is free, and from then on
// the next request is accepted, so the time a request takes is set by the length of
// the cell chain. Zero-size allocations and frees of a block beyond the table end
// skip the chain: their result is registered at acceptance and moved on likewise.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; if the receiver stalls and a second result is
// ready, the block holds it and accepts nothing further until the first is taken.
// Reset clears the table (entry count and heap top to zero) and sets the heap
// limit to 65536; no clearing pass is needed.
module best_fit_block_allocator #(
  parameter int MAX_BLOCKS   = bfba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = bfba_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = bfba_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request beats.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bfba_pkg::IN_DATA_W-1:0]    in_tdata,   // request_size[31:0], target_block[37:32]
  input  logic                              in_tuser,   // kind[0]
  // Result beats.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bfba_pkg::OUT_DATA_W-1:0]   out_tdata,  // data_address[31:0], block_number[37:32],
                                                        // reused[38]
  output logic [1:0]                        out_tuser,  // status[1:0]
  // Heap limit write.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [31:0]                       cfg_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = ADDR_BITS;
  localparam int LW = (AW > 32) ? AW : 32;
  localparam int NW = LW + 1;
  localparam int KW = (CW > bfba_pkg::TGT_W) ? CW : bfba_pkg::TGT_W;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_BLOCKS);
  localparam logic [LW-1:0] ADDR_MASK  = LW'({AW{1'b1}});

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state_r;

  logic [31:0]    heap_limit_r;
  logic [AW-1:0]  heap_top_r;
  logic [CW-1:0]  count_r;

  // Request under way.
  logic                       kind_r;
  logic [bfba_pkg::REQ_W-1:0] req_r;
  logic [IW-1:0]              tgt_r;
  logic [NW-1:0]              need_r;

  // Room check against the heap limit.
  logic [LW-1:0] limit_eff;
  logic [LW-1:0] diff_r;
  logic          over_r;
  logic          fit_r;

  // Launched token.
  bfba_pkg::tok_ctl_t launch_r;

  // Pending result and table update.
  bfba_pkg::status_t          res_status_r;
  logic [bfba_pkg::DADDR_W-1:0] res_addr_r;
  logic [bfba_pkg::BLKNUM_W-1:0] res_blk_r;
  logic                        res_reused_r;
  bfba_pkg::commit_op_t       cmt_op_r;
  logic [IW-1:0]              cmt_idx_r;
  logic [AW-1:0]              cmt_start_r;
  logic [bfba_pkg::REQ_W-1:0] cmt_size_r;

  // Output register.
  logic                        out_valid_r;
  bfba_pkg::status_t           out_status_r;
  logic [bfba_pkg::DADDR_W-1:0] out_addr_r;
  logic [bfba_pkg::BLKNUM_W-1:0] out_blk_r;
  logic                        out_reused_r;

  // Token chain wiring, one slot per cell boundary.
  bfba_pkg::tok_ctl_t          tok_ctl   [0:MAX_BLOCKS];
  logic [bfba_pkg::REQ_W-1:0]  tok_size  [0:MAX_BLOCKS];
  logic [IW-1:0]               tok_idx   [0:MAX_BLOCKS];
  logic [AW-1:0]               tok_start [0:MAX_BLOCKS];

  // Decoded input beat.
  logic                        in_kind;
  logic [bfba_pkg::REQ_W-1:0]  in_size;
  logic [bfba_pkg::TGT_W-1:0]  in_target;
  logic                        in_fire;
  logic                        tgt_missing;
  logic                        skip_chain;
  logic                        out_free;
  logic                        cmt_fire;
  bfba_pkg::commit_op_t        cmt_op;

  // Decision at token arrival.
  bfba_pkg::status_t           dec_status;
  logic [bfba_pkg::DADDR_W-1:0] dec_addr;
  logic [bfba_pkg::BLKNUM_W-1:0] dec_blk;
  logic                        dec_reused;
  bfba_pkg::commit_op_t        dec_op;
  logic [IW-1:0]               dec_idx;

  // Heap offset of the data behind a block header, reduced to the address width.
  function automatic logic [bfba_pkg::DADDR_W-1:0] data_addr(input logic [AW-1:0] start);
    logic [AW-1:0] sum;
    sum = start + AW'(HEADER_BYTES);
    return bfba_pkg::DADDR_W'(sum);
  endfunction

  assign in_kind   = in_tuser;
  assign in_size   = in_tdata[bfba_pkg::REQ_W-1:0];
  assign in_target = in_tdata[bfba_pkg::REQ_W +: bfba_pkg::TGT_W];

  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign tgt_missing = (KW'(in_target) >= KW'(count_r));
  assign out_free    = !out_valid_r || out_tready;
  assign cmt_fire    = (state_r == S_FINISH) && out_free;
  assign cmt_op      = cmt_fire ? cmt_op_r : bfba_pkg::CMT_NONE;
  assign cfg_ready   = 1'b1;

  // Requests answered without walking the chain.
  assign skip_chain = ((in_kind == bfba_pkg::KIND_FREE) && tgt_missing) ||
                      ((in_kind == bfba_pkg::KIND_ALLOC) && (in_size == '0));

  // Heap limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= bfba_pkg::HEAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      heap_limit_r <= cfg_data;
    end
  end

  // Room left below the limit, settled while the token walks the chain.
  always_comb begin
    limit_eff = (LW'(heap_limit_r) > ADDR_MASK) ? ADDR_MASK : LW'(heap_limit_r);
  end

  always_ff @(posedge clk) begin
    over_r <= (LW'(heap_top_r) > limit_eff);
    diff_r <= limit_eff - LW'(heap_top_r);
    fit_r  <= !over_r && (need_r <= NW'(diff_r));
  end

  // Result and table update once the token leaves the last cell.
  always_comb begin
    dec_status = bfba_pkg::ST_OK;
    dec_addr   = '0;
    dec_blk    = '0;
    dec_reused = 1'b0;
    dec_op     = bfba_pkg::CMT_NONE;
    dec_idx    = tok_idx[MAX_BLOCKS];
    if (kind_r == bfba_pkg::KIND_FREE) begin
      dec_addr = data_addr(tok_start[MAX_BLOCKS]);
      dec_blk  = bfba_pkg::BLKNUM_W'(tgt_r);
      dec_idx  = tgt_r;
      if (tok_ctl[MAX_BLOCKS].was_free) begin
        dec_status = bfba_pkg::ST_BADFREE;
      end else begin
        dec_op = bfba_pkg::CMT_SET_FREE;
      end
    end else if (tok_ctl[MAX_BLOCKS].found) begin
      dec_addr   = data_addr(tok_start[MAX_BLOCKS]);
      dec_blk    = bfba_pkg::BLKNUM_W'(tok_idx[MAX_BLOCKS]);
      dec_reused = 1'b1;
      dec_op     = bfba_pkg::CMT_CLR_FREE;
    end else if ((count_r == COUNT_FULL) || !fit_r) begin
      dec_status = bfba_pkg::ST_NOSPACE;
    end else begin
      dec_addr = data_addr(heap_top_r);
      dec_blk  = bfba_pkg::BLKNUM_W'(count_r);
      dec_op   = bfba_pkg::CMT_APPEND;
      dec_idx  = IW'(count_r);
    end
  end

  // Request payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      req_r  <= in_size;
      tgt_r  <= IW'(in_target);
      need_r <= NW'(in_size) + NW'(HEADER_BYTES);
    end
  end

  // Sequencer with the table counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= '0;
      heap_top_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmt_op_r    <= bfba_pkg::CMT_NONE;
    end else begin
      launch_r.valid <= in_fire && !skip_chain;
      // The output beat is loaded when the result leaves and held until it is taken.
      out_valid_r <= cmt_fire || (out_valid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_addr_r   <= '0;
            res_reused_r <= 1'b0;
            cmt_op_r     <= bfba_pkg::CMT_NONE;
            if (in_kind == bfba_pkg::KIND_FREE && tgt_missing) begin
              res_status_r <= bfba_pkg::ST_BADFREE;
              res_blk_r    <= in_target;
              state_r      <= S_FINISH;
            end else if (in_kind == bfba_pkg::KIND_ALLOC && in_size == '0) begin
              res_status_r <= bfba_pkg::ST_ZERO;
              res_blk_r    <= '0;
              state_r      <= S_FINISH;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (tok_ctl[MAX_BLOCKS].valid) begin
            res_status_r <= dec_status;
            res_addr_r   <= dec_addr;
            res_blk_r    <= dec_blk;
            res_reused_r <= dec_reused;
            cmt_op_r     <= dec_op;
            cmt_idx_r    <= dec_idx;
            cmt_start_r  <= heap_top_r;
            cmt_size_r   <= req_r;
            state_r      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_blk_r    <= res_blk_r;
            out_reused_r <= res_reused_r;
            if (cmt_op_r == bfba_pkg::CMT_APPEND) begin
              heap_top_r <= heap_top_r + AW'(need_r);
              count_r    <= count_r + CW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Head of the chain: a fresh token with no candidate.
  assign tok_ctl[0]   = launch_r;
  assign tok_size[0]  = '0;
  assign tok_idx[0]   = '0;
  assign tok_start[0] = '0;

  // Row of cells, one per table entry.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    bfba_cell #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS),
      .IDX        (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .req_kind    (kind_r),
      .req_size    (req_r),
      .req_target  (tgt_r),
      .entry_count (count_r),
      .tok_ctl_i   (tok_ctl[g]),
      .tok_size_i  (tok_size[g]),
      .tok_idx_i   (tok_idx[g]),
      .tok_start_i (tok_start[g]),
      .tok_ctl_o   (tok_ctl[g+1]),
      .tok_size_o  (tok_size[g+1]),
      .tok_idx_o   (tok_idx[g+1]),
      .tok_start_o (tok_start[g+1]),
      .cmt_op      (cmt_op),
      .cmt_idx     (cmt_idx_r),
      .cmt_start   (cmt_start_r),
      .cmt_size    (cmt_size_r)
    );
  end

  // Result beat.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_reused_r, out_blk_r, out_addr_r};

endmodule
